// ----- hdl/ysma_pkg.sv -----
// ysma_pkg: shared types and constants of the yearly seasonal mean aggregator
// no dependencies; used by the channel interfaces and the top level

package ysma_pkg;

  localparam int YEAR_W     = 14;
  localparam int MONTH_W    = 4;
  localparam int TEMP_W     = 16;
  localparam int MEAN_W     = 16;
  localparam int LIMIT_W    = 15;
  localparam int MIN_DAYS_W = 10;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_ADDR_W-1:0] CFG_TEMP_LIMIT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_DAYS   = 1'd1;

  localparam logic [LIMIT_W-1:0]    TEMP_LIMIT_RST = 15'd500;
  localparam logic [MIN_DAYS_W-1:0] MIN_DAYS_RST   = 10'd330;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_EMIT
  } ysma_state_t;

  typedef enum logic [1:0] {
    SEL_ANNUAL,
    SEL_SUMMER,
    SEL_WINTER
  } mean_sel_t;

endpackage

// ----- hdl/ysma_if.sv -----
// ysma_in_if / ysma_out_if: valid-ready channels for records and yearly results
// depends on ysma_pkg for field widths

interface ysma_in_if;
  import ysma_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     is_end;
  logic [YEAR_W-1:0]        rec_year;
  logic [MONTH_W-1:0]       rec_month;
  logic signed [TEMP_W-1:0] temperature;

  modport source (output valid, is_end, rec_year, rec_month, temperature, input ready);
  modport sink   (input valid, is_end, rec_year, rec_month, temperature, output ready);
endinterface

interface ysma_out_if;
  import ysma_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [YEAR_W-1:0]        out_year;
  logic signed [MEAN_W-1:0] annual_mean;
  logic signed [MEAN_W-1:0] summer_mean;
  logic signed [MEAN_W-1:0] winter_mean;
  logic                     valid_res;

  modport source (output valid, out_year, annual_mean, summer_mean, winter_mean, valid_res,
                  input ready);
  modport sink   (input valid, out_year, annual_mean, summer_mean, winter_mean, valid_res,
                  output ready);
endinterface

// ----- hdl/ysma_div.sv -----
// ysma_div: iterative restoring divider, signed numerator by unsigned denominator,
// floor-rounded quotient; one quotient bit per cycle; no package dependencies

module ysma_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic        [DEN_W-1:0] den,
  output logic                    done,
  output logic signed [NUM_W-1:0] quot
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              neg_r, neg_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W:0]    trial;
  logic [NUM_W-1:0]  num_mag;

  always_comb begin
    num_mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    trial    = {rem_r, quo_r[NUM_W-1]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(NUM_W);
      neg_nxt  = num[NUM_W-1];
      quo_nxt  = num_mag;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  // floor rounding: a negative quotient with a remainder moves down by one
  always_comb begin
    if (!neg_r) begin
      quot = signed'(quo_r);
    end else if (rem_r != '0) begin
      quot = signed'(~quo_r);
    end else begin
      quot = signed'(NUM_W'(-quo_r));
    end
  end

  assign done = done_r;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && den_r != '0) |-> rem_r < den_r)
    else $error("divider remainder not below denominator");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start)
    else $error("divider restarted while busy");
`endif

endmodule

// ----- hdl/yearly_seasonal_mean_aggregator_unit.sv -----
// yearly_seasonal_mean_aggregator_unit: per-year temperature sums and seasonal means
// depends on ysma_pkg, ysma_if (ysma_in_if, ysma_out_if) and ysma_div
//
// in_ch takes daily records (year, month, temperature) or an end marker.
// out_ch gives one item per closed year: year, floor annual, summer (Jun-Aug)
// and winter (Dec-Feb) means and valid_res; means read 0 when valid_res is 0.
// cfg_we/cfg_addr/cfg_wdata write temp_limit (index 0) and min_days (index 1);
// the user must write them only while the block is idle; the block does not enforce it.
// A record that stays in the open year is added in S_IDLE; in_ch.ready stays
// high. An item that closes a year runs three divisions (annual, summer,
// winter) on one shared restoring divider, one quotient bit per cycle; in_ch
// takes no record until the three means are passed on in S_EMIT.
// The result lands in an output register; the next record is accepted while
// it waits. If the receiver stalls and another year closes, the second result
// waits in the divider stage until the output register frees, in_ch stays low.
// Reset clears all sums and counts, closes the open year and loads temp_limit
// 500 and min_days 330.

module yearly_seasonal_mean_aggregator_unit #(
  parameter int DAY_COUNT_MAX = 1023
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ysma_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [ysma_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  ysma_in_if.sink                           in_ch,
  ysma_out_if.source                        out_ch
);

  import ysma_pkg::*;

  localparam int CNT_W = $clog2(DAY_COUNT_MAX + 1);
  localparam int SUM_W = TEMP_W + CNT_W;
  localparam int CMP_W = (CNT_W > MIN_DAYS_W) ? CNT_W : MIN_DAYS_W;

  ysma_state_t state_r, state_nxt;
  mean_sel_t   sel_r, sel_nxt;

  logic [LIMIT_W-1:0]    limit_r;
  logic [MIN_DAYS_W-1:0] min_days_r;

  logic                    year_open_r, year_open_nxt;
  logic [YEAR_W-1:0]       open_year_r, open_year_nxt;
  logic signed [SUM_W-1:0] asum_r, asum_nxt;
  logic signed [SUM_W-1:0] ssum_r, ssum_nxt;
  logic signed [SUM_W-1:0] wsum_r, wsum_nxt;
  logic [CNT_W-1:0]        dcnt_r, dcnt_nxt;
  logic [CNT_W-1:0]        scnt_r, scnt_nxt;
  logic [CNT_W-1:0]        wcnt_r, wcnt_nxt;

  logic                     pend_end_r, pend_end_nxt;
  logic [YEAR_W-1:0]        pend_year_r, pend_year_nxt;
  logic [MONTH_W-1:0]       pend_month_r, pend_month_nxt;
  logic signed [TEMP_W-1:0] pend_temp_r, pend_temp_nxt;

  logic signed [MEAN_W-1:0] amean_r, amean_nxt;
  logic signed [MEAN_W-1:0] smean_r, smean_nxt;
  logic signed [MEAN_W-1:0] wmean_r, wmean_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [YEAR_W-1:0]        out_year_r, out_year_nxt;
  logic signed [MEAN_W-1:0] out_amean_r, out_amean_nxt;
  logic signed [MEAN_W-1:0] out_smean_r, out_smean_nxt;
  logic signed [MEAN_W-1:0] out_wmean_r, out_wmean_nxt;
  logic                     out_ok_r, out_ok_nxt;

  logic                    div_start, div_done;
  logic signed [SUM_W-1:0] div_num, div_quot;
  logic [CNT_W-1:0]        div_den;

  // accumulate path
  logic                     acc_apply, acc_clear, acc_pend;
  logic [MONTH_W-1:0]       acc_month;
  logic signed [TEMP_W-1:0] acc_temp;
  logic signed [TEMP_W:0]   t_wide;
  logic [TEMP_W:0]          t_mag;
  logic signed [SUM_W-1:0]  t_sum;
  logic signed [SUM_W-1:0]  a_base, s_base, w_base;
  logic [CNT_W-1:0]         d_base, sc_base, wc_base;
  logic                     qual, is_winter, is_summer;
  logic                     year_ok;
  logic signed [MEAN_W-1:0] div_mean;

  always_comb begin
    acc_month = acc_pend ? pend_month_r : in_ch.rec_month;
    acc_temp  = acc_pend ? pend_temp_r  : in_ch.temperature;
    t_wide    = (TEMP_W+1)'(acc_temp);
    t_mag     = t_wide[TEMP_W] ? unsigned'((TEMP_W+1)'(-t_wide)) : unsigned'(t_wide);
    t_sum     = SUM_W'(acc_temp);
    a_base    = acc_clear ? '0 : asum_r;
    s_base    = acc_clear ? '0 : ssum_r;
    w_base    = acc_clear ? '0 : wsum_r;
    d_base    = acc_clear ? '0 : dcnt_r;
    sc_base   = acc_clear ? '0 : scnt_r;
    wc_base   = acc_clear ? '0 : wcnt_r;
    qual      = (t_mag < (TEMP_W+1)'(limit_r)) && (d_base < CNT_W'(DAY_COUNT_MAX));
    is_winter = (acc_month == MONTH_DEC) || (acc_month == MONTH_JAN) ||
                (acc_month == MONTH_FEB);
    is_summer = (acc_month >= MONTH_JUN) && (acc_month <= MONTH_AUG);
    year_ok   = (CMP_W'(dcnt_r) >= CMP_W'(min_days_r)) && (asum_r != '0) &&
                (dcnt_r != '0);
  end

  always_comb begin
    case (sel_r)
      SEL_SUMMER: begin
        div_num = ssum_r;
        div_den = scnt_r;
      end
      SEL_WINTER: begin
        div_num = wsum_r;
        div_den = wcnt_r;
      end
      default: begin
        div_num = asum_r;
        div_den = dcnt_r;
      end
    endcase
    div_mean = div_quot[MEAN_W-1:0];
  end

  ysma_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt      = state_r;
    sel_nxt        = sel_r;
    year_open_nxt  = year_open_r;
    open_year_nxt  = open_year_r;
    asum_nxt       = asum_r;
    ssum_nxt       = ssum_r;
    wsum_nxt       = wsum_r;
    dcnt_nxt       = dcnt_r;
    scnt_nxt       = scnt_r;
    wcnt_nxt       = wcnt_r;
    pend_end_nxt   = pend_end_r;
    pend_year_nxt  = pend_year_r;
    pend_month_nxt = pend_month_r;
    pend_temp_nxt  = pend_temp_r;
    amean_nxt      = amean_r;
    smean_nxt      = smean_r;
    wmean_nxt      = wmean_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_year_nxt   = out_year_r;
    out_amean_nxt  = out_amean_r;
    out_smean_nxt  = out_smean_r;
    out_wmean_nxt  = out_wmean_r;
    out_ok_nxt     = out_ok_r;
    in_ch.ready    = 1'b0;
    div_start      = 1'b0;
    acc_apply      = 1'b0;
    acc_clear      = 1'b0;
    acc_pend       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          pend_end_nxt   = in_ch.is_end;
          pend_year_nxt  = in_ch.rec_year;
          pend_month_nxt = in_ch.rec_month;
          pend_temp_nxt  = in_ch.temperature;
          if (in_ch.is_end) begin
            if (year_open_r) begin
              sel_nxt   = SEL_ANNUAL;
              state_nxt = S_START;
            end
          end else if (!year_open_r || (in_ch.rec_year == open_year_r)) begin
            acc_apply     = 1'b1;
            acc_clear     = !year_open_r;
            year_open_nxt = 1'b1;
            open_year_nxt = in_ch.rec_year;
          end else begin
            sel_nxt   = SEL_ANNUAL;
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        div_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          case (sel_r)
            SEL_ANNUAL: begin
              amean_nxt = year_ok ? div_mean : '0;
              sel_nxt   = SEL_SUMMER;
              state_nxt = S_START;
            end
            SEL_SUMMER: begin
              smean_nxt = (year_ok && (scnt_r != '0)) ? div_mean : '0;
              sel_nxt   = SEL_WINTER;
              state_nxt = S_START;
            end
            default: begin
              wmean_nxt = (year_ok && (wcnt_r != '0)) ? div_mean : '0;
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_EMIT: begin
        acc_pend = 1'b1;
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_year_nxt  = open_year_r;
          out_amean_nxt = amean_r;
          out_smean_nxt = smean_r;
          out_wmean_nxt = wmean_r;
          out_ok_nxt    = year_ok;
          acc_clear     = 1'b1;
          if (pend_end_r) begin
            year_open_nxt = 1'b0;
            open_year_nxt = '0;
            asum_nxt      = '0;
            ssum_nxt      = '0;
            wsum_nxt      = '0;
            dcnt_nxt      = '0;
            scnt_nxt      = '0;
            wcnt_nxt      = '0;
          end else begin
            acc_apply     = 1'b1;
            year_open_nxt = 1'b1;
            open_year_nxt = pend_year_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (acc_apply) begin
      asum_nxt = a_base;
      ssum_nxt = s_base;
      wsum_nxt = w_base;
      dcnt_nxt = d_base;
      scnt_nxt = sc_base;
      wcnt_nxt = wc_base;
      if (qual) begin
        asum_nxt = a_base + t_sum;
        dcnt_nxt = d_base + CNT_W'(1);
        if (is_winter) begin
          wsum_nxt = w_base + t_sum;
          wcnt_nxt = wc_base + CNT_W'(1);
        end
        if (is_summer) begin
          ssum_nxt = s_base + t_sum;
          scnt_nxt = sc_base + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= TEMP_LIMIT_RST;
      min_days_r <= MIN_DAYS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TEMP_LIMIT: limit_r    <= cfg_wdata[LIMIT_W-1:0];
        CFG_MIN_DAYS:   min_days_r <= cfg_wdata[MIN_DAYS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= SEL_ANNUAL;
      year_open_r <= 1'b0;
      open_year_r <= '0;
      asum_r      <= '0;
      ssum_r      <= '0;
      wsum_r      <= '0;
      dcnt_r      <= '0;
      scnt_r      <= '0;
      wcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      year_open_r <= year_open_nxt;
      open_year_r <= open_year_nxt;
      asum_r      <= asum_nxt;
      ssum_r      <= ssum_nxt;
      wsum_r      <= wsum_nxt;
      dcnt_r      <= dcnt_nxt;
      scnt_r      <= scnt_nxt;
      wcnt_r      <= wcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_end_r   <= pend_end_nxt;
    pend_year_r  <= pend_year_nxt;
    pend_month_r <= pend_month_nxt;
    pend_temp_r  <= pend_temp_nxt;
    amean_r      <= amean_nxt;
    smean_r      <= smean_nxt;
    wmean_r      <= wmean_nxt;
    out_year_r   <= out_year_nxt;
    out_amean_r  <= out_amean_nxt;
    out_smean_r  <= out_smean_nxt;
    out_wmean_r  <= out_wmean_nxt;
    out_ok_r     <= out_ok_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_year    = out_year_r;
  assign out_ch.annual_mean = out_amean_r;
  assign out_ch.summer_mean = out_smean_r;
  assign out_ch.winter_mean = out_wmean_r;
  assign out_ch.valid_res   = out_ok_r;

`ifndef SYNTHESIS
  a_day_cap: assert property (@(posedge clk) disable iff (!rst_n)
    dcnt_r <= CNT_W'(DAY_COUNT_MAX))
    else $error("day count above its cap");
  a_season_le_days: assert property (@(posedge clk) disable iff (!rst_n)
    ((CNT_W+1)'(scnt_r) + (CNT_W+1)'(wcnt_r)) <= (CNT_W+1)'(dcnt_r))
    else $error("season counts exceed day count");
  a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !year_open_r |-> (dcnt_r == '0 && asum_r == '0))
    else $error("totals held with no open year");
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |->
      (out_amean_r == '0 && out_smean_r == '0 && out_wmean_r == '0))
    else $error("invalid year reports nonzero mean");
  a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_WAIT)
    else $error("division finished outside the wait step");
`endif

endmodule
